// ----- rtl/nsdq_pkg.sv -----
// Package for the noise-shaped dither quantizer: widths, payload structs,
// output-width decode and the dither generator step. No dependencies.
package nsdq_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ACC_W     = 38;
  localparam int ERR_W     = 34;
  localparam int SB_W      = 5;
  localparam int OB_W      = 5;
  localparam int PEAK_W    = 29;
  localparam int OVER_W    = 33;
  localparam int CNT_W     = 32;
  localparam int PCM_W     = 24;
  localparam int SMP_W     = 32;
  localparam int MAX_BITS  = (FRAC_BITS < 24) ? FRAC_BITS : 24;
  localparam int MIN_BITS  = 8;

  localparam logic signed [ACC_W-1:0] LVL_TOP = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LVL_BOT = -LVL_TOP - 1;

  localparam logic [31:0] LCG_MUL = 32'h0019_660d;
  localparam logic [31:0] LCG_INC = 32'h3c6e_f35f;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    frame_start;
  } nsdq_req_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic                    clipped;
    logic [CNT_W-1:0]        clip_count;
    logic [PEAK_W-1:0]       peak_level;
    logic [OVER_W-1:0]       peak_overshoot;
  } nsdq_res_t;

  typedef struct packed {
    logic [31:0] cur;
    logic [31:0] rnd;
  } nsdq_dith_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    lcg_next = s * LCG_MUL + LCG_INC;
  endfunction

  function automatic logic [SB_W-1:0] bits_to_shift(input logic [OB_W-1:0] ob);
    int b;
    b = int'(ob);
    if (b < MIN_BITS) b = MIN_BITS;
    if (b > MAX_BITS) b = MAX_BITS;
    bits_to_shift = SB_W'(FRAC_BITS + 1 - b);
  endfunction

  localparam logic [31:0] LCG_FIRST  = lcg_next(32'd0);
  localparam logic [31:0] LCG_SECOND = lcg_next(LCG_FIRST);

endpackage

// ----- rtl/nsdq_dither.sv -----
// Dither generator: congruential state with one value of lookahead so the
// multiplier stays off the sample path. Depends on nsdq_pkg.
module nsdq_dither import nsdq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic       clear_i,
  output nsdq_dith_t dith_o
);

  logic [31:0] lcg_q, lcg_d;
  logic [31:0] nxt_q, nxt_d;

  always_comb begin
    if (clear_i) begin
      dith_o.cur = '0;
      dith_o.rnd = LCG_FIRST;
      lcg_d      = LCG_FIRST;
      nxt_d      = LCG_SECOND;
    end else begin
      dith_o.cur = lcg_q;
      dith_o.rnd = nxt_q;
      lcg_d      = nxt_q;
      nxt_d      = lcg_next(nxt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= '0;
      nxt_q <= LCG_FIRST;
    end else if (advance_i) begin
      lcg_q <= lcg_d;
      nxt_q <= nxt_d;
    end
  end

endmodule

// ----- rtl/nsdq_core.sv -----
// Quantizer datapath: error feedback, bias, dither, clip, truncate and clip
// statistics, with the error history and statistics registers. Depends on nsdq_pkg.
module nsdq_core import nsdq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  nsdq_req_t       req_i,
  input  logic [SB_W-1:0] shift_i,
  input  nsdq_dith_t      dith_i,
  output nsdq_res_t       res_o
);

  logic signed [ERR_W-1:0]  err_now_q, err_prev_q, err_prev2_q;
  logic signed [ERR_W-1:0]  err_now_d, err_prev_d;
  logic [CNT_W-1:0]         clip_total_q, clip_total_d;
  logic [PEAK_W-1:0]        peak_mag_q, peak_mag_d;
  logic [OVER_W-1:0]        peak_over_q, peak_over_d;

  logic                     clr;
  logic signed [ERR_W-1:0]  e0, e1, e2;
  logic [ERR_W-1:0]         e0_adj;
  logic [CNT_W-1:0]         cnt;
  logic [PEAK_W-1:0]        peak;
  logic [OVER_W-1:0]        over;
  logic signed [ACC_W-1:0]  x, x_c, level, lvl_c, dith, q, shifted, err;
  logic signed [ACC_W-1:0]  peak_s, over_s, diff_hi, diff_lo, neg_lvl;
  logic [ACC_W-1:0]         lvl_mask, bias;
  logic [31:0]              mask32;
  logic                     clip;

  assign clr  = req_i.frame_start;
  assign e0   = clr ? '0 : err_now_q;
  assign e1   = clr ? '0 : err_prev_q;
  assign e2   = clr ? '0 : err_prev2_q;
  assign cnt  = clr ? '0 : clip_total_q;
  assign peak = clr ? '0 : peak_mag_q;
  assign over = clr ? '0 : peak_over_q;

  assign lvl_mask = (ACC_W'(1) << shift_i) - ACC_W'(1);
  assign bias     = ACC_W'(1) << (shift_i - SB_W'(1));
  assign mask32   = lvl_mask[31:0];

  assign x = $signed({{(ACC_W-SMP_W){req_i.sample[SMP_W-1]}}, req_i.sample})
           + $signed({{(ACC_W-ERR_W){e0[ERR_W-1]}}, e0})
           - $signed({{(ACC_W-ERR_W){e1[ERR_W-1]}}, e1})
           + $signed({{(ACC_W-ERR_W){e2[ERR_W-1]}}, e2});

  assign dith  = $signed({{(ACC_W-32){1'b0}}, dith_i.rnd & mask32})
               - $signed({{(ACC_W-32){1'b0}}, dith_i.cur & mask32});
  assign level = x + $signed(bias) + dith;

  assign peak_s  = $signed({{(ACC_W-PEAK_W){1'b0}}, peak});
  assign over_s  = $signed({{(ACC_W-OVER_W){1'b0}}, over});
  assign diff_hi = level - LVL_TOP;
  assign diff_lo = LVL_BOT - level;

  always_comb begin
    clip        = 1'b0;
    lvl_c       = level;
    x_c         = x;
    peak_mag_d  = peak;
    peak_over_d = over;
    if (level >= peak_s) begin
      if (level > LVL_TOP) begin
        clip  = 1'b1;
        lvl_c = LVL_TOP;
        if (diff_hi > over_s) peak_over_d = diff_hi[OVER_W-1:0];
        if (x > LVL_TOP) x_c = LVL_TOP;
      end
      peak_mag_d = lvl_c[PEAK_W-1:0];
    end else if (level < -peak_s) begin
      if (level < LVL_BOT) begin
        clip  = 1'b1;
        lvl_c = LVL_BOT;
        if (diff_lo > over_s) peak_over_d = diff_lo[OVER_W-1:0];
        if (x < LVL_BOT) x_c = LVL_BOT;
      end
      peak_mag_d = neg_lvl[PEAK_W-1:0];
    end
  end

  assign neg_lvl = (level < LVL_BOT) ? -LVL_BOT : -level;

  assign q       = $signed(lvl_c & ~lvl_mask);
  assign shifted = q >>> shift_i;
  assign err     = x_c - q;

  assign err_now_d    = err[ERR_W-1:0];
  assign e0_adj       = e0 + {{(ERR_W-1){1'b0}}, e0[ERR_W-1]};
  assign err_prev_d   = {e0_adj[ERR_W-1], e0_adj[ERR_W-1:1]};
  assign clip_total_d = (clip && (cnt != '1)) ? cnt + CNT_W'(1) : cnt;

  assign res_o.pcm            = shifted[PCM_W-1:0];
  assign res_o.clipped        = clip;
  assign res_o.clip_count     = clip_total_d;
  assign res_o.peak_level     = peak_mag_d;
  assign res_o.peak_overshoot = peak_over_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_now_q    <= '0;
      err_prev_q   <= '0;
      err_prev2_q  <= '0;
      clip_total_q <= '0;
      peak_mag_q   <= '0;
      peak_over_q  <= '0;
    end else if (advance_i) begin
      err_now_q    <= err_now_d;
      err_prev_q   <= err_prev_d;
      err_prev2_q  <= e1;
      clip_total_q <= clip_total_d;
      peak_mag_q   <= peak_mag_d;
      peak_over_q  <= peak_over_d;
    end
  end

endmodule

// ----- rtl/noise_shaped_dither_quantizer_top.sv -----
// Top level of the noise-shaped dither quantizer: request and result
// registers, output width register. Depends on nsdq_pkg, nsdq_dither, nsdq_core.

// Accepts one sample request per cycle while the result is not stalled and
// returns one result per request: the request is captured in an input register,
// and a single pass of feedback, dither, clip and truncate logic updates the
// error history and clip statistics and loads the result register. The error
// feedback loop closes within that single pass, which sets the rate; the dither
// generator runs one value ahead so its multiplier is not in that loop. A
// stalled result holds the pipe; no start-up pass is needed after reset.
// Write the output width only while no request is in flight.
module noise_shaped_dither_quantizer_top import nsdq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  nsdq_req_t       in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output nsdq_res_t       out_res_o,
  input  logic            cfg_we_i,
  input  logic [OB_W-1:0] cfg_wdata_i
);

  logic            req_valid_q;
  nsdq_req_t       req_q;
  logic            res_valid_q;
  nsdq_res_t       res_q;
  nsdq_res_t       res_d;
  logic [SB_W-1:0] shift_q;
  logic            advance;
  logic            accept;
  nsdq_dith_t      dith;

  assign advance    = req_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  nsdq_dither u_dither (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .clear_i   (req_q.frame_start),
    .dith_o    (dith)
  );

  nsdq_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (req_q),
    .shift_i   (shift_q),
    .dith_i    (dith),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      shift_q     <= bits_to_shift(OB_W'(16));
    end else begin
      if (accept) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        shift_q <= bits_to_shift(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

endmodule

// ----- tb/sv/noise_shaped_dither_quantizer_top_tb.sv -----
// Self-checking testbench for noise_shaped_dither_quantizer_top: bursty requests,
// patterned result stalls, a quantizer predictor and field-wise checks.
// Depends on nsdq_pkg and the RTL of the block.
module noise_shaped_dither_quantizer_top_tb;
  import nsdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH_AT_RESET = 16;
  localparam int LONG_HOLD      = 150;
  localparam int MAX_SHOWN      = 10;
  localparam int PHASE_ITEMS    = 59;
  localparam realtime RUN_LIMIT = 2_000_000ns;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_DENSE, RX_COMB} rx_mode_e;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  nsdq_req_t       in_req_i    = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  nsdq_res_t       out_res_o;
  logic            cfg_we_i    = 1'b0;
  logic [OB_W-1:0] cfg_wdata_i = '0;

  nsdq_req_t sample_q[$];
  nsdq_res_t quant_q[$];
  int        miscompares = 0;
  bit        hold_tx = 1'b0;
  int        hold_reqs = 0;
  int        hold_done = 0;
  int        tx_burst, tx_gap;
  int        rx_hold, rx_mode_left;
  rx_mode_e  rx_mode;
  logic [7:0] rx_phase;

  logic [OB_W-1:0]          width_reg;
  logic signed [ERR_W-1:0]  fb_err0, fb_err1, fb_err2;
  logic [31:0]              dith_seed;
  logic [CNT_W-1:0]         clips_seen;
  logic [PEAK_W-1:0]        level_peak;
  logic [OVER_W-1:0]        excess_peak;

  noise_shaped_dither_quantizer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void clear_history();
    fb_err0     = '0;
    fb_err1     = '0;
    fb_err2     = '0;
    dith_seed   = '0;
    clips_seen  = '0;
    level_peak  = '0;
    excess_peak = '0;
  endfunction

  function automatic nsdq_res_t quantize_sample(input nsdq_req_t req);
    nsdq_res_t   res;
    longint      top, bot, x, level, step, rem, q;
    int          b, sb;
    logic [31:0] nxt, msk;
    bit          clip;
    top = (longint'(1) << FRAC_BITS) - 1;
    bot = -(longint'(1) << FRAC_BITS);
    if (req.frame_start) clear_history();
    b = int'(width_reg);
    if (b < MIN_BITS) b = MIN_BITS;
    if (b > 24) b = 24;
    if (b > FRAC_BITS) b = FRAC_BITS;
    sb   = FRAC_BITS + 1 - b;
    step = longint'(1) << sb;
    msk  = 32'(step - 1);

    x = longint'(req.sample) + longint'(fb_err0) - longint'(fb_err1) + longint'(fb_err2);
    fb_err2 = fb_err1;
    fb_err1 = ERR_W'(longint'(fb_err0) / 2);

    level = x + (longint'(1) << (sb - 1));
    nxt   = dith_seed * 32'h0019_660d + 32'h3c6e_f35f;
    level = level + longint'(nxt & msk) - longint'(dith_seed & msk);
    dith_seed = nxt;

    clip = 1'b0;
    if (level >= longint'(level_peak)) begin
      if (level > top) begin
        clip = 1'b1;
        if (level - top > longint'(excess_peak)) excess_peak = OVER_W'(level - top);
        level = top;
        if (x > top) x = top;
      end
      level_peak = PEAK_W'(level);
    end else if (level < -longint'(level_peak)) begin
      if (level < bot) begin
        clip = 1'b1;
        if (bot - level > longint'(excess_peak)) excess_peak = OVER_W'(bot - level);
        level = bot;
        if (x < bot) x = bot;
      end
      level_peak = PEAK_W'(-level);
    end
    if (clip && clips_seen != '1) clips_seen = clips_seen + 1'b1;

    rem = level % step;
    if (rem < 0) rem = rem + step;
    q = level - rem;
    fb_err0 = ERR_W'(x - q);

    res.pcm            = PCM_W'(q / step);
    res.clipped        = clip;
    res.clip_count     = clips_seen;
    res.peak_level     = level_peak;
    res.peak_overshoot = excess_peak;
    return res;
  endfunction

  function automatic nsdq_req_t random_request();
    nsdq_req_t r;
    int        pick;
    pick = $urandom_range(0, 99);
    r.frame_start = ($urandom_range(0, 29) == 0);
    if (pick < 55) begin
      r.sample = $signed($urandom) >>> $urandom_range(3, 14);
    end else if (pick < 75) begin
      r.sample = ($urandom_range(0, 1) ? 32'h1000_0000 : 32'hf000_0000)
                 + $urandom_range(0, 8192) - 32'd4096;
    end else if (pick < 90) begin
      r.sample = $urandom;
    end else begin
      r.sample = $urandom_range(0, 63) - 32'd32;
    end
    return r;
  endfunction

  task automatic push_item(input logic [SMP_W-1:0] s, input logic fs);
    nsdq_req_t r;
    r.sample      = s;
    r.frame_start = fs;
    sample_q.push_back(r);
  endtask

  task automatic note_miscompare(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    miscompares++;
    if (miscompares <= MAX_SHOWN)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid_i || quant_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [OB_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      tx_burst   <= 0;
      tx_gap     <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (hold_tx || sample_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (tx_gap != 0) begin
        in_valid_i <= 1'b0;
        tx_gap     <= tx_gap - 1;
      end else begin
        in_valid_i <= 1'b1;
        in_req_i   <= sample_q.pop_front();
        if (tx_burst > 1) begin
          tx_burst <= tx_burst - 1;
        end else begin
          tx_burst <= $urandom_range(1, 48);
          tx_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      rx_hold      <= 0;
      rx_mode      <= RX_OPEN;
      rx_mode_left <= 0;
      rx_phase     <= '0;
    end else if (hold_reqs != hold_done) begin
      hold_done   <= hold_reqs;
      rx_hold     <= LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold     <= rx_hold - 1;
      out_stall_i <= 1'b1;
    end else begin
      rx_phase <= rx_phase + 1'b1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_stall_i <= 1'b0;
        RX_SPARSE: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_DENSE:  out_stall_i <= ($urandom_range(0, 3) != 0);
        default:   out_stall_i <= (rx_phase[2:0] < 3'd3);
      endcase
    end
  end

  // predict on every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = OB_W'(WIDTH_AT_RESET);
      clear_history();
    end else begin
      if (cfg_we_i) width_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) quant_q.push_back(quantize_sample(in_req_i));
    end
  end

  always @(posedge clk_i) begin : result_check
    nsdq_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quant_q.size() == 0) begin
        note_miscompare("unexpected result pcm", '0, 64'(out_res_o.pcm));
      end else begin
        want = quant_q.pop_front();
        if (out_res_o.pcm !== want.pcm)
          note_miscompare("pcm", 64'(want.pcm), 64'(out_res_o.pcm));
        if (out_res_o.clipped !== want.clipped)
          note_miscompare("clipped", 64'(want.clipped), 64'(out_res_o.clipped));
        if (out_res_o.clip_count !== want.clip_count)
          note_miscompare("clip_count", 64'(want.clip_count), 64'(out_res_o.clip_count));
        if (out_res_o.peak_level !== want.peak_level)
          note_miscompare("peak_level", 64'(want.peak_level), 64'(out_res_o.peak_level));
        if (out_res_o.peak_overshoot !== want.peak_overshoot)
          note_miscompare("peak_overshoot", 64'(want.peak_overshoot),
                          64'(out_res_o.peak_overshoot));
      end
    end
  end

  initial begin : stimulus
    int        width_plan[$] = '{0, 31, 8, 24, 7, 25, 12, 20, -1, -1, 16};
    int        p, k;
    nsdq_req_t r;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset width: range ends, clipping both ways, peak rise and fall, frame restart
    push_item(32'h0000_0000, 1'b1);
    push_item(32'h0000_0000, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item(32'hffff_ffff, 1'b0);
    push_item(32'h0080_0000, 1'b0);
    push_item(32'h0100_0000, 1'b0);
    push_item(32'h0200_0000, 1'b0);
    push_item(32'h0040_0000, 1'b0);
    push_item(32'hfc00_0000, 1'b0);
    push_item(32'h0fff_ffff, 1'b0);
    push_item(32'h1000_0000, 1'b0);
    push_item(32'hf000_0000, 1'b0);
    push_item(32'hefff_ffff, 1'b0);
    push_item(32'h7fff_ffff, 1'b0);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h0800_0000, 1'b0);
    push_item(32'hf800_0000, 1'b0);
    push_item(32'h7fff_ffff, 1'b1);
    push_item(32'h0000_0000, 1'b1);

    for (p = 0; p < width_plan.size(); p++) begin
      drain();
      write_width(width_plan[p] < 0 ? OB_W'($urandom_range(0, 31)) : OB_W'(width_plan[p]));
      @(negedge clk_i);
      r = random_request();
      r.frame_start = 1'b1;
      sample_q.push_back(r);
      for (k = 0; k < PHASE_ITEMS; k++) sample_q.push_back(random_request());
      if (p == 3) begin
        hold_reqs++;
      end else if (p == 6) begin
        while (sample_q.size() > 30) @(negedge clk_i);
        hold_tx = 1'b1;
        while (in_valid_i || quant_q.size() != 0) @(negedge clk_i);
        hold_tx = 1'b0;
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (miscompares == 0 && quant_q.size() == 0) begin
      $display("** noise_shaped_dither_quantizer_top: PASSED **");
    end else begin
      $display("** noise_shaped_dither_quantizer_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT;
    $display("** noise_shaped_dither_quantizer_top: FAILED **");
    $finish;
  end

endmodule
